// ===== hdl/crs_pkg.sv =====
`default_nettype none
package crs_pkg;

   // Store geometry.
   localparam int MAX_POINTS = 64;
   localparam int PTR_W      = $clog2(MAX_POINTS);
   localparam int IDX_W      = 6;
   localparam int CNT_W      = 7;
   localparam int CNT_MIN    = 4;
   localparam int RD_PORTS   = 4;

   // Field widths.
   localparam int COORD_W = 32;
   localparam int FRAC_W  = 17;
   localparam int T_W     = FRAC_W + 1;

   // Request data layout, lowest bit first.
   localparam int REQ_IDX_LSB  = 0;
   localparam int REQ_X_LSB    = REQ_IDX_LSB + IDX_W;
   localparam int REQ_Y_LSB    = REQ_X_LSB + COORD_W;
   localparam int REQ_Z_LSB    = REQ_Y_LSB + COORD_W;
   localparam int REQ_FRAC_LSB = REQ_Z_LSB + COORD_W;
   localparam int REQ_BITS     = REQ_FRAC_LSB + FRAC_W;
   localparam int REQ_DATA_W   = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_W   = 3 * COORD_W;

   // Command codes carried in req_tuser.
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_EVAL  = 1'b1;

   // Pipeline depth: stage 1 is the store read, the last stage the output register.
   localparam int NUM_STAGES = 8;

   // Internal arithmetic widths, each with headroom over its worst case.
   localparam int B_W  = COORD_W + 2;
   localparam int C_W  = COORD_W + 5;
   localparam int D_W  = COORD_W + 4;
   localparam int DP_W = D_W + T_W;
   localparam int G_W  = COORD_W + 8;
   localparam int GP_W = G_W + T_W;
   localparam int H_W  = COORD_W + 10;
   localparam int HP_W = H_W + T_W;
   localparam int S_W  = COORD_W + 12;

   localparam logic signed [COORD_W-1:0] POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] POS_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type z;
      coord_type y;
      coord_type x;
   } point_type;

   typedef logic [NUM_STAGES:1] stage_vec_type;

endpackage
`default_nettype wire

// ===== hdl/catmull_rom_spline_eval_core.sv =====
`default_nettype none
// An evaluate request goes through all eight stages before its response shows on rsp_*.
// Throughput: one request per cycle unless stalled; each stage holds an item, moving on its own.
// A write request gives no response; an evaluate right after it sees the new point.
// Reset (synchronous, active high) empties the pipeline, holds req_tready low and sets
// points_in_use to 4. The point store is not cleared: an entry reads as garbage until written.
module catmull_rom_spline_eval_core
   import crs_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // Request channel.
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,  // index, coord_x, coord_y, coord_z, fraction
   input  wire logic                  req_tuser,  // command
   // Response channel.
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,  // pos_x, pos_y, pos_z
   output logic                       rsp_tuser,  // was_clamped
   // Configuration: points_in_use.
   input  wire logic                  csr_we,
   input  wire logic [CNT_W-1:0]      csr_wdata
);

   // The request fields, unpacked from tdata.
   logic [IDX_W-1:0]  req_index;
   point_type         req_point;
   logic [FRAC_W-1:0] req_frac;

   assign req_index   = req_tdata[REQ_IDX_LSB +: IDX_W];
   assign req_point.x = req_tdata[REQ_X_LSB +: COORD_W];
   assign req_point.y = req_tdata[REQ_Y_LSB +: COORD_W];
   assign req_point.z = req_tdata[REQ_Z_LSB +: COORD_W];
   assign req_frac    = req_tdata[REQ_FRAC_LSB +: FRAC_W];

   // Configuration register.
   logic [CNT_W-1:0] points_in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         points_in_use_ff <= CNT_W'(CNT_MIN);
      end else if (csr_we) begin
         points_in_use_ff <= csr_wdata;
      end
   end

   // Stage advance: a stage loads when it is empty or its contents move on.
   // The chain runs back from the output register, so a stall only freezes the
   // stages that are full behind it and bubbles are squeezed out.
   stage_vec_type v_ff, clamp_ff, ld;

   always_comb begin
      ld[NUM_STAGES] = !v_ff[NUM_STAGES] || rsp_tready;
      for (int k = NUM_STAGES - 1; k >= 1; k--) begin
         ld[k] = !v_ff[k] || ld[k+1];
      end
   end

   logic req_acc, wr_en, eval_acc;

   // No request is taken while reset is held, so none can be lost there.
   assign req_tready = ld[1] && !reset;
   assign req_acc    = req_tvalid && req_tready;
   assign wr_en      = req_acc && (req_tuser == CMD_WRITE);
   assign eval_acc   = req_acc && (req_tuser == CMD_EVAL);

   // Stage 0: effective point count, range check and the four store addresses.
   // In range, the segment uses points i-1, i, i+1 and i+2, where the last
   // segment repeats the end point. Out of range, port 1 fetches the end point
   // that is returned as it is.
   logic [CNT_W-1:0] cnt_eff, last_pt, seg_max, idx_ext, idx_p2;
   logic             idx_high, idx_low, clamp_s0;
   logic [PTR_W-1:0] rd_addr [RD_PORTS];

   always_comb begin
      if (points_in_use_ff < CNT_W'(CNT_MIN)) begin
         cnt_eff = CNT_W'(CNT_MIN);
      end else if (points_in_use_ff > CNT_W'(MAX_POINTS)) begin
         cnt_eff = CNT_W'(MAX_POINTS);
      end else begin
         cnt_eff = points_in_use_ff;
      end
      last_pt  = cnt_eff - CNT_W'(1);
      seg_max  = cnt_eff - CNT_W'(2);
      idx_ext  = CNT_W'(req_index);
      idx_p2   = idx_ext + CNT_W'(2);
      idx_high = idx_ext > seg_max;
      idx_low  = idx_ext == '0;
      clamp_s0 = idx_high || idx_low;

      rd_addr[0] = PTR_W'(idx_ext - CNT_W'(1));
      rd_addr[2] = PTR_W'(idx_ext + CNT_W'(1));
      rd_addr[3] = (idx_p2 > last_pt) ? last_pt[PTR_W-1:0] : idx_p2[PTR_W-1:0];
      if (idx_high) begin
         rd_addr[1] = seg_max[PTR_W-1:0];
      end else if (idx_low) begin
         rd_addr[1] = PTR_W'(1);
      end else begin
         rd_addr[1] = req_index[PTR_W-1:0];
      end
   end

   // Point store: one copy per read port, all written together, so that the
   // four points of a segment come out in the same cycle. Each copy has one
   // write and one registered read per cycle.
   point_type rd_ff [RD_PORTS];
   logic [FRAC_W-1:0] frac_s1_ff;

   for (genvar k = 0; k < RD_PORTS; k++) begin : g_copy
      point_type copy_mem [MAX_POINTS];

      always_ff @(posedge clock) begin
         if (wr_en) begin
            copy_mem[req_index[PTR_W-1:0]] <= req_point;
         end
         if (ld[1]) begin
            rd_ff[k] <= copy_mem[rd_addr[k]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         frac_s1_ff <= req_frac;
      end
   end

   // Valid and clamp flags travel alongside the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (ld[1]) begin
            v_ff[1] <= eval_acc;
         end
         for (int k = 2; k <= NUM_STAGES; k++) begin
            if (ld[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld[1]) begin
         clamp_ff[1] <= clamp_s0;
      end
      for (int k = 2; k <= NUM_STAGES; k++) begin
         if (ld[k]) begin
            clamp_ff[k] <= clamp_ff[k-1];
         end
      end
   end

   // One arithmetic pipeline per axis.
   coord_type pos_x, pos_y, pos_z;

   crs_axis u_axis_x (
      .clock    (clock),
      .adv      (ld),
      .p0       (rd_ff[0].x),
      .p1       (rd_ff[1].x),
      .p2       (rd_ff[2].x),
      .p3       (rd_ff[3].x),
      .frac_s1  (frac_s1_ff),
      .clamp_s7 (clamp_ff[NUM_STAGES-1]),
      .pos      (pos_x)
   );

   crs_axis u_axis_y (
      .clock    (clock),
      .adv      (ld),
      .p0       (rd_ff[0].y),
      .p1       (rd_ff[1].y),
      .p2       (rd_ff[2].y),
      .p3       (rd_ff[3].y),
      .frac_s1  (frac_s1_ff),
      .clamp_s7 (clamp_ff[NUM_STAGES-1]),
      .pos      (pos_y)
   );

   crs_axis u_axis_z (
      .clock    (clock),
      .adv      (ld),
      .p0       (rd_ff[0].z),
      .p1       (rd_ff[1].z),
      .p2       (rd_ff[2].z),
      .p3       (rd_ff[3].z),
      .frac_s1  (frac_s1_ff),
      .clamp_s7 (clamp_ff[NUM_STAGES-1]),
      .pos      (pos_z)
   );

   assign rsp_tvalid = v_ff[NUM_STAGES];
   assign rsp_tdata  = {pos_z, pos_y, pos_x};
   assign rsp_tuser  = clamp_ff[NUM_STAGES];

   // A write never puts an item into the pipeline, an evaluate always does.
   a_write_no_item: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> !v_ff[1])
      else $error("write request entered the pipeline");

   a_eval_enters: assert property (@(posedge clock) disable iff (reset)
      eval_acc |=> v_ff[1])
      else $error("evaluate request lost at pipeline entry");

   // An in-range segment reads consecutive points, the fourth never before the third.
   a_seg_addr: assert property (@(posedge clock) disable iff (reset)
      (eval_acc && !clamp_s0) |->
         (rd_addr[2] == rd_addr[1] + PTR_W'(1)) && (rd_addr[3] >= rd_addr[2])
         && (rd_addr[1] == rd_addr[0] + PTR_W'(1)))
      else $error("segment addresses out of order");

   // A stalled response stays valid and keeps its clamp flag and pos_x.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (v_ff[NUM_STAGES] && !rsp_tready) |=>
         v_ff[NUM_STAGES] && $stable(clamp_ff[NUM_STAGES]) && $stable(pos_x))
      else $error("stalled response changed");

endmodule
`default_nettype wire

// ===== hdl/crs_axis.sv =====
`default_nettype none
module crs_axis
   import crs_pkg::*;
(
   input  wire logic             clock,
   input  wire stage_vec_type    adv,        // per-stage load enables
   input  wire coord_type        p0,
   input  wire coord_type        p1,
   input  wire coord_type        p2,
   input  wire coord_type        p3,
   input  wire logic [FRAC_W-1:0] frac_s1,
   input  wire logic             clamp_s7,   // pass p1 through untouched
   output coord_type             pos
);

   // Stage 2: polynomial coefficients.
   logic signed [B_W-1:0]  b_in, b_s2_ff, b_s3_ff, b_s4_ff, b_s5_ff;
   logic signed [C_W-1:0]  c_in, c_s2_ff, c_s3_ff;
   logic signed [D_W-1:0]  d_in, d_s2_ff, diff12;
   coord_type              p1_s2_ff, p1_s3_ff, p1_s4_ff, p1_s5_ff, p1_s6_ff, p1_s7_ff;
   logic [FRAC_W-1:0]      t_s2_ff, t_s3_ff, t_s4_ff, t_s5_ff, t_s6_ff;

   logic signed [DP_W-1:0] dp_in, dp_s3_ff, dp_rnd;
   logic signed [G_W-1:0]  g_in, g_s4_ff;
   logic signed [GP_W-1:0] gp_in, gp_s5_ff, gp_rnd;
   logic signed [H_W-1:0]  h_in, h_s6_ff;
   logic signed [HP_W-1:0] hp_in, hp_s7_ff, hp_rnd;
   logic signed [S_W-1:0]  sum;
   coord_type              pos_in, pos_ff;

   always_comb begin
      b_in   = B_W'(p2) - B_W'(p0);
      c_in   = (C_W'(p0) <<< 1) - ((C_W'(p1) <<< 2) + C_W'(p1))
             + (C_W'(p2) <<< 2) - C_W'(p3);
      diff12 = D_W'(p1) - D_W'(p2);
      d_in   = (diff12 <<< 1) + diff12 + D_W'(p3) - D_W'(p0);

      dp_in  = DP_W'(d_s2_ff) * DP_W'($signed({1'b0, t_s2_ff}));

      dp_rnd = dp_s3_ff + DP_W'(32768);
      g_in   = G_W'(dp_rnd >>> 16) + G_W'(c_s3_ff);

      gp_in  = GP_W'(g_s4_ff) * GP_W'($signed({1'b0, t_s4_ff}));

      gp_rnd = gp_s5_ff + GP_W'(32768);
      h_in   = H_W'(gp_rnd >>> 16) + H_W'(b_s5_ff);

      hp_in  = HP_W'(h_s6_ff) * HP_W'($signed({1'b0, t_s6_ff}));

      hp_rnd = hp_s7_ff + HP_W'(65536);
      sum    = S_W'(p1_s7_ff) + S_W'(hp_rnd >>> 17);
      if (clamp_s7) begin
         pos_in = p1_s7_ff;
      end else if (sum > S_W'(POS_MAX)) begin
         pos_in = POS_MAX;
      end else if (sum < S_W'(POS_MIN)) begin
         pos_in = POS_MIN;
      end else begin
         pos_in = COORD_W'(sum);
      end
   end

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         b_s2_ff  <= b_in;
         c_s2_ff  <= c_in;
         d_s2_ff  <= d_in;
         p1_s2_ff <= p1;
         t_s2_ff  <= frac_s1;
      end
      if (adv[3]) begin
         dp_s3_ff <= dp_in;
         c_s3_ff  <= c_s2_ff;
         b_s3_ff  <= b_s2_ff;
         p1_s3_ff <= p1_s2_ff;
         t_s3_ff  <= t_s2_ff;
      end
      if (adv[4]) begin
         g_s4_ff  <= g_in;
         b_s4_ff  <= b_s3_ff;
         p1_s4_ff <= p1_s3_ff;
         t_s4_ff  <= t_s3_ff;
      end
      if (adv[5]) begin
         gp_s5_ff <= gp_in;
         b_s5_ff  <= b_s4_ff;
         p1_s5_ff <= p1_s4_ff;
         t_s5_ff  <= t_s4_ff;
      end
      if (adv[6]) begin
         h_s6_ff  <= h_in;
         p1_s6_ff <= p1_s5_ff;
         t_s6_ff  <= t_s5_ff;
      end
      if (adv[7]) begin
         hp_s7_ff <= hp_in;
         p1_s7_ff <= p1_s6_ff;
      end
      if (adv[8]) begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule
`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the Catmull-Rom spline evaluator.
//
// Write requests load control points into the store of the block. Evaluate
// requests return one position each. A predictor in this module keeps its own
// copy of the point store and of the points_in_use register, and predicts each
// untyped evaluate with the same fixed-point rounding as the block. Each
// response is compared field by field with the oldest expected position.
module tb;
   import crs_pkg::*;

   // One request, as the stimulus sees it. The expected fields are filled in
   // only for directed rows whose result can be read off directly; all other
   // rows leave typed at zero and go through the predictor.
   typedef struct packed {
      logic                cmd;
      logic [IDX_W-1:0]    index;
      coord_type           x;
      coord_type           y;
      coord_type           z;
      logic [FRAC_W-1:0]   frac;
      bit                  typed;
      coord_type           ex;
      coord_type           ey;
      coord_type           ez;
      logic                eclamp;
   } request_row;

   // One response of the block.
   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type z;
      logic      clamped;
   } spline_position;

   // Number of requests in each random phase.
   localparam int PHASE_REQUESTS = 95;
   localparam int NUM_PHASES     = 6;
   // Cycles that the receiver holds off in the pressure phase.
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int PRESSURE_PHASE  = 4;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = CMD_WRITE;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_we     = 1'b0;
   logic [CNT_W-1:0]      csr_wdata  = '0;

   // Predictor state: the point store and the points_in_use register.
   coord_type        store_x [MAX_POINTS];
   coord_type        store_y [MAX_POINTS];
   coord_type        store_z [MAX_POINTS];
   logic [CNT_W-1:0] points_in_use = CNT_W'(CNT_MIN);

   // Positions still owed by the block, oldest first.
   spline_position pending_positions[$];

   // Idling controls, set by the stimulus and read by the sender and receiver.
   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   bit hold_off_armed = 1'b0;
   bit hold_off_used  = 1'b0;
   int hold_left      = 0;

   int error_count     = 0;
   int writes_sent     = 0;
   int evals_sent      = 0;
   int results_checked = 0;
   int clamped_seen    = 0;

   // Directed part. The store starts empty, so the first four rows load every
   // point that an evaluate can touch while points_in_use is four.
   request_row directed_rows [21] = '{
      // Load points 0 to 3, among them the extremes of the coordinate range.
      '{CMD_WRITE, 6'd0,  32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000, 17'h0,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_WRITE, 6'd1,  32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 17'h0,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_WRITE, 6'd2,  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 17'h0,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_WRITE, 6'd3,  32'h0000_0000, 32'h0001_0000, 32'h7FFF_FFFF, 17'h0,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      // The top slot of the store; it is not read while only four points are in use.
      '{CMD_WRITE, 6'd63, 32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 17'h0,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      // At t = 0 the curve sits on the start point of the segment.
      '{CMD_EVAL,  6'd1,  32'h0, 32'h0, 32'h0, 17'h0_0000,
        1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b0},
      // At t = 1.0 it sits on the end point of the segment.
      '{CMD_EVAL,  6'd1,  32'h0, 32'h0, 32'h0, 17'h1_0000,
        1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b0},
      // An index below one returns point one, flagged as clamped.
      '{CMD_EVAL,  6'd0,  32'h0, 32'h0, 32'h0, 17'h0_8000,
        1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1234_5678, 1'b1},
      // An index above count minus two returns that point, flagged as clamped.
      '{CMD_EVAL,  6'd3,  32'h0, 32'h0, 32'h0, 17'h0_8000,
        1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1},
      '{CMD_EVAL,  6'd63, 32'h0, 32'h0, 32'h0, 17'h1_FFFF,
        1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b1},
      // Last segment: the missing fourth point repeats the end point.
      '{CMD_EVAL,  6'd2,  32'h0, 32'h0, 32'h0, 17'h0_8000,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      // Fractions above 1.0 extrapolate and drive the sums into saturation.
      '{CMD_EVAL,  6'd1,  32'h0, 32'h0, 32'h0, 17'h1_FFFF,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_EVAL,  6'd2,  32'h0, 32'h0, 32'h0, 17'h1_FFFF,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_EVAL,  6'd1,  32'h0, 32'h0, 32'h0, 17'h1_0001,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_EVAL,  6'd1,  32'h0, 32'h0, 32'h0, 17'h0_0001,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      // An evaluate right behind a write must see the new point.
      '{CMD_WRITE, 6'd2,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_8000, 17'h0,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_EVAL,  6'd2,  32'h0, 32'h0, 32'h0, 17'h0_0000,
        1'b1, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0001_8000, 1'b0},
      '{CMD_EVAL,  6'd1,  32'h0, 32'h0, 32'h0, 17'h0_AAAA,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_EVAL,  6'd2,  32'h0, 32'h0, 32'h0, 17'h1_5555,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_WRITE, 6'd1,  32'h0000_8000, 32'h0000_0000, 32'hFFFF_FFFF, 17'h0,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0},
      '{CMD_EVAL,  6'd1,  32'h0, 32'h0, 32'h0, 17'h0_C000,
        1'b0, 32'h0, 32'h0, 32'h0, 1'b0}
   };

   // The register value for each random phase, with the send and stall rates.
   // Values below four and above the store size exercise the count limits.
   int phase_counts [NUM_PHASES] = '{127, 0, 64, 5, 37, 3};
   int phase_gaps   [NUM_PHASES] = '{0, 52, 0, 23, 0, 52};
   int phase_stalls [NUM_PHASES] = '{0, 0, 52, 23, 0, 23};

   catmull_rom_spline_eval_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The register value as the block uses it: held between four and the store size.
   function automatic int effective_count();
      int c = int'(points_in_use);
      if (c < CNT_MIN) begin
         return CNT_MIN;
      end
      if (c > MAX_POINTS) begin
         return MAX_POINTS;
      end
      return c;
   endfunction

   // One coordinate of the cubic in Horner form. The arithmetic right shift of
   // a signed 64-bit value is a floor division, which is the rounding wanted.
   function automatic coord_type spline_axis(input longint p0, input longint p1,
                                             input longint p2, input longint p3,
                                             input longint t);
      longint b;
      longint c;
      longint d;
      longint g;
      longint h;
      longint s;
      b = p2 - p0;
      c = 2 * p0 - 5 * p1 + 4 * p2 - p3;
      d = -p0 + 3 * p1 - 3 * p2 + p3;
      g = ((d * t + 64'sd32768) >>> 16) + c;
      h = ((g * t + 64'sd32768) >>> 16) + b;
      s = p1 + ((h * t + 64'sd65536) >>> 17);
      if (s > longint'(POS_MAX)) begin
         return POS_MAX;
      end
      if (s < longint'(POS_MIN)) begin
         return POS_MIN;
      end
      return coord_type'(s);
   endfunction

   // Expected response of an evaluate with segment index idx and parameter frac.
   function automatic spline_position predict_position(input int idx, input int frac);
      spline_position pos;
      int cnt;
      int last;
      int e;
      int i3;
      cnt  = effective_count();
      last = cnt - 2;
      if (idx > last || idx < 1) begin
         // Out of range: hand back the nearest end point unchanged.
         e = (idx > last) ? last : 1;
         pos = '{store_x[e], store_y[e], store_z[e], 1'b1};
         return pos;
      end
      i3 = (idx + 2 > cnt - 1) ? cnt - 1 : idx + 2;
      pos.x = spline_axis(store_x[idx-1], store_x[idx], store_x[idx+1], store_x[i3], frac);
      pos.y = spline_axis(store_y[idx-1], store_y[idx], store_y[idx+1], store_y[i3], frac);
      pos.z = spline_axis(store_z[idx-1], store_z[idx], store_z[idx+1], store_z[i3], frac);
      pos.clamped = 1'b0;
      return pos;
   endfunction

   // Applies an accepted request to the predictor.
   function automatic void apply_request(input request_row row);
      if (row.cmd == CMD_WRITE) begin
         if (int'(row.index) < MAX_POINTS) begin
            store_x[row.index] = row.x;
            store_y[row.index] = row.y;
            store_z[row.index] = row.z;
         end
      end else begin
         pending_positions.push_back(predict_position(int'(row.index), int'(row.frac)));
      end
   endfunction

   function automatic coord_type random_coord();
      case ($urandom_range(7))
         0: return POS_MAX;
         1: return POS_MIN;
         2: return coord_type'(int'($urandom_range(32'h0040_0000)) - 32'sh0020_0000);
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic logic [FRAC_W-1:0] random_fraction();
      case ($urandom_range(9))
         0: return '0;
         1: return FRAC_W'(17'h1_0000);
         2: return FRAC_W'($urandom_range(17'h1_FFFF));
         default: return FRAC_W'($urandom_range(17'h1_0000));
      endcase
   endfunction

   // Mostly evaluates on real segments of the current curve, with writes that
   // reshape it, and a share of indexes anywhere, which may end up clamped.
   function automatic request_row random_request();
      request_row row;
      int cnt;
      row = '0;
      cnt = effective_count();
      if ($urandom_range(99) < 30) begin
         row.cmd   = CMD_WRITE;
         row.index = IDX_W'($urandom_range(1) ? $urandom_range(cnt - 1) : $urandom_range(63));
         row.x     = random_coord();
         row.y     = random_coord();
         row.z     = random_coord();
      end else begin
         row.cmd   = CMD_EVAL;
         row.index = IDX_W'(($urandom_range(99) < 80) ? $urandom_range(cnt - 2, 1)
                                                      : $urandom_range(63));
         row.frac  = random_fraction();
      end
      return row;
   endfunction

   // Offers one request, with random idle cycles ahead of it, and waits until
   // the block takes it. The predictor sees the request at the accepting edge.
   task automatic send_request(input request_row row);
      logic [REQ_DATA_W-1:0] data;
      data = '0;
      data[REQ_IDX_LSB  +: IDX_W]   = row.index;
      data[REQ_X_LSB    +: COORD_W] = row.x;
      data[REQ_Y_LSB    +: COORD_W] = row.y;
      data[REQ_Z_LSB    +: COORD_W] = row.z;
      data[REQ_FRAC_LSB +: FRAC_W]  = row.frac;
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= row.cmd;
      // Right after the edge, req_tready still shows its value before the edge.
      do @(posedge clock); while (!req_tready);
      if (row.cmd == CMD_WRITE) begin
         writes_sent++;
      end else begin
         evals_sent++;
      end
      if (row.typed) begin
         pending_positions.push_back('{row.ex, row.ey, row.ez, row.eclamp});
      end else begin
         apply_request(row);
      end
   endtask

   // Writes points_in_use once the block has gone quiet. A write request gives
   // no response, so the pipeline is also left idle to drain first.
   task automatic set_point_count(input int value);
      while (pending_positions.size() != 0) begin
         @(posedge clock);
      end
      repeat (NUM_STAGES + 2) @(posedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CNT_W'(value);
      @(posedge clock);
      points_in_use = CNT_W'(value);
      csr_we <= 1'b0;
   endtask

   // Receiver: checks each accepted response, then decides whether to stall
   // in the next cycle. In the pressure phase it holds off for a long stretch
   // so that the pipeline fills and the block pushes back on its input.
   always @(posedge clock) begin
      spline_position want;
      spline_position got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata[0 +: COORD_W], rsp_tdata[COORD_W +: COORD_W],
                 rsp_tdata[2*COORD_W +: COORD_W], rsp_tuser};
         results_checked++;
         if (rsp_tuser) begin
            clamped_seen++;
         end
         if (pending_positions.size() == 0) begin
            $display("%0t: response with none expected: x %h y %h z %h clamped %b",
                     $time, got.x, got.y, got.z, got.clamped);
            error_count++;
         end else begin
            want = pending_positions.pop_front();
            if (got.x !== want.x) begin
               $display("%0t: pos_x expected %h actual %h", $time, want.x, got.x);
               error_count++;
            end
            if (got.y !== want.y) begin
               $display("%0t: pos_y expected %h actual %h", $time, want.y, got.y);
               error_count++;
            end
            if (got.z !== want.z) begin
               $display("%0t: pos_z expected %h actual %h", $time, want.z, got.z);
               error_count++;
            end
            if (got.clamped !== want.clamped) begin
               $display("%0t: was_clamped expected %b actual %b",
                        $time, want.clamped, got.clamped);
               error_count++;
            end
         end
      end
      if (hold_off_armed && !hold_off_used) begin
         hold_left     = HOLD_OFF_CYCLES;
         hold_off_used = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Main sequence: reset, directed rows, a full load of the store, then the
   // random phases under different counts and idling patterns.
   initial begin
      request_row row;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset leaves four points in use; write it anyway so the register is
      // exercised right out of reset.
      set_point_count(CNT_MIN);
      foreach (directed_rows[i]) begin
         send_request(directed_rows[i]);
      end

      // Fill every slot so that no later evaluate reads an unwritten point.
      for (int s = 0; s < MAX_POINTS; s++) begin
         row       = '0;
         row.cmd   = CMD_WRITE;
         row.index = IDX_W'(s);
         row.x     = random_coord();
         row.y     = random_coord();
         row.z     = random_coord();
         send_request(row);
      end
      req_tvalid <= 1'b0;

      for (int p = 0; p < NUM_PHASES; p++) begin
         set_point_count(phase_counts[p]);
         send_gap_pct   = phase_gaps[p];
         recv_stall_pct = phase_stalls[p];
         if (p == PRESSURE_PHASE) begin
            hold_off_armed = 1'b1;
         end
         for (int n = 0; n < PHASE_REQUESTS; n++) begin
            send_request(random_request());
         end
         req_tvalid <= 1'b0;
      end

      // Drain the pipeline, then wait on for stray responses.
      recv_stall_pct = 0;
      while (pending_positions.size() != 0) begin
         @(posedge clock);
      end
      repeat (NUM_STAGES + 4) @(posedge clock);

      $display("Covered %0d point writes and %0d evaluates over %0d register settings.",
               writes_sent, evals_sent, NUM_PHASES + 1);
      $display("Checked %0d positions, %0d of them clamped to an end point.",
               results_checked, clamped_seen);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run including the long hold-off.
   initial begin
      #2000000;
      $display("Timeout: block stopped making progress");
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
